>>> rtl/core/lrm_pkg.sv
// lrm_pkg: shared types and constants for the linear range map
// no dependencies
package lrm_pkg;

    localparam int DataW = 16;
    localparam int NumW = 32;
    localparam int QueueDepth = 4;
    localparam int CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SOURCE_LOW  = 2'd0,
        REG_SOURCE_HIGH = 2'd1,
        REG_TARGET_LOW  = 2'd2,
        REG_TARGET_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_LOW  = 2'd0,
        KIND_HIGH = 2'd1,
        KIND_DIV  = 2'd2
    } kind_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t            kind;
        logic             descend;
        logic [NumW-1:0]  numer;
        logic [DataW-1:0] span;
        logic [DataW-1:0] base;
        logic [DataW-1:0] clamp;
    } job_t;

endpackage

>>> rtl/core/lrm_front.sv
// lrm_front: range tests, offset times delta, rounding term
// depends on lrm_pkg
module lrm_front import lrm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [DataW-1:0] sample,
    input  logic [DataW-1:0] source_low,
    input  logic [DataW-1:0] source_high,
    input  logic [DataW-1:0] target_low,
    input  logic [DataW-1:0] target_high,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic             v_reg;
    job_t             job_reg, job_next;
    logic [DataW-1:0] offset, span, delta;
    logic             descend;

    assign in_ready  = !v_reg || job_ready;
    assign job_valid = v_reg;
    assign job       = job_reg;

    always_comb begin
        descend = target_high < target_low;
        offset  = sample - source_low;
        span    = source_high - source_low;
        delta   = descend ? target_low - target_high : target_high - target_low;
        job_next.descend = descend;
        job_next.span    = span;
        job_next.base    = target_low;
        job_next.numer   = (NumW'(offset) * NumW'(delta)) + NumW'(span >> 1);
        job_next.clamp   = target_high;
        if (sample < source_low) begin
            job_next.kind  = KIND_LOW;
            job_next.clamp = target_low;
        end else if (sample >= source_high) begin
            job_next.kind = KIND_HIGH;
        end else begin
            job_next.kind = KIND_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            job_reg <= job_next;
        end
    end

endmodule

>>> rtl/core/lrm_queue.sv
// lrm_queue: short fifo between front and back
// depends on lrm_pkg
module lrm_queue import lrm_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    job_t              mem [Depth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;
    logic              wr, rd;

    assign wr_ready = cnt_reg != (PtrW+1)'(Depth);
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = mem[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == PtrW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == PtrW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(wr) - (PtrW+1)'(rd);
        end
        if (wr) mem[wp_reg] <= wr_job;
    end

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PtrW+1)'(Depth)) else $error("queue count overflow");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wp_reg == rp_reg)) else $error("queue pointers split");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == (PtrW+1)'(Depth)) |-> (wp_reg == rp_reg))
        else $error("queue full pointers split");

endmodule

>>> rtl/core/lrm_back.sv
// lrm_back: pipelined restoring divider, one quotient bit a stage, and output register
// depends on lrm_pkg
module lrm_back import lrm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  job_t             job,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DataW-1:0] result
);

    localparam int Stages = NumW;

    typedef struct packed {
        kind_t            kind;
        logic             descend;
        logic [DataW:0]   rem;
        logic [NumW-1:0]  quo;
        logic [DataW-1:0] span;
        logic [DataW-1:0] base;
        logic [DataW-1:0] clamp;
    } stage_t;

    logic   v_reg [Stages+1];
    stage_t s_reg [Stages+1];
    stage_t s_next [Stages];
    logic   adv;
    logic [DataW-1:0] res_next;
    stage_t last;

    // whole pipe moves when the output register is free
    assign adv       = !v_reg[Stages] || out_ready;
    assign job_ready = adv;
    assign out_valid = v_reg[Stages];
    assign last      = s_reg[Stages];

    always_comb begin
        for (int i = 0; i < Stages; i++) begin
            logic [DataW+1:0] trial;
            s_next[i] = s_reg[i];
            trial = {s_reg[i].rem, s_reg[i].quo[NumW-1]} - {2'b00, s_reg[i].span};
            s_next[i].quo = {s_reg[i].quo[NumW-2:0], ~trial[DataW+1]};
            s_next[i].rem = trial[DataW+1] ? {s_reg[i].rem[DataW-1:0], s_reg[i].quo[NumW-1]}
                                           : trial[DataW:0];
        end
    end

    always_comb begin
        case (last.kind)
            KIND_DIV: res_next = last.descend ? last.base - last.quo[DataW-1:0]
                                              : last.base + last.quo[DataW-1:0];
            default:  res_next = last.clamp;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= Stages; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= job_valid;
            for (int i = 1; i <= Stages; i++) v_reg[i] <= v_reg[i-1];
        end
        if (adv) begin
            s_reg[0].kind    <= job.kind;
            s_reg[0].descend <= job.descend;
            s_reg[0].rem     <= '0;
            s_reg[0].quo     <= job.numer;
            s_reg[0].span    <= job.span;
            s_reg[0].base    <= job.base;
            s_reg[0].clamp   <= job.clamp;
            for (int i = 1; i <= Stages; i++) s_reg[i] <= s_next[i-1];
        end
    end

    // final stage register doubles as output holding; result taken from it
    assign result = res_next;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> $stable(result)) else $error("result moved");
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("valid dropped");
    a_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && last.kind == KIND_DIV) |-> (last.quo[NumW-1:DataW] == '0))
        else $error("quotient too wide");

endmodule

>>> rtl/core/linear_range_map_rounded_u16.sv
// linear_range_map_rounded_u16: top level, config registers, front, queue, back
// depends on lrm_pkg, lrm_front, lrm_queue, lrm_back
//
// channel  | dir | payload
// s_axis   | in  | tdata[15:0] sample_value
// m_axis   | out | tdata[15:0] mapped_value
// cfg      | in  | cfg_index[1:0], cfg_data[15:0]
//
// one item per cycle sustained while m_axis is ready; without stalls the path is 1 front
// register, 1 queue slot and 33 divider stages ending in the output register.
// reset (aresetn low, synchronous) restores register defaults and empties all
// stages. a stall on m_axis freezes the divider pipe; the queue keeps the
// front accepting until it fills.
module linear_range_map_rounded_u16 import lrm_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DataW-1:0]   s_axis_tdata,   // sample_value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DataW-1:0]   m_axis_tdata,   // mapped_value
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DataW-1:0]   cfg_data
);

    logic [DataW-1:0] sl_reg, sh_reg, tl_reg, th_reg;
    logic fv, fr, bv, br;
    job_t fj, bj;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sl_reg <= '0;
            sh_reg <= '1;
            tl_reg <= '0;
            th_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SOURCE_LOW:  sl_reg <= cfg_data;
                REG_SOURCE_HIGH: sh_reg <= cfg_data;
                REG_TARGET_LOW:  tl_reg <= cfg_data;
                REG_TARGET_HIGH: th_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lrm_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .sample(s_axis_tdata),
        .source_low(sl_reg), .source_high(sh_reg),
        .target_low(tl_reg), .target_high(th_reg),
        .job_valid(fv), .job_ready(fr), .job(fj)
    );

    lrm_queue #(.Depth(Depth)) u_queue (
        .aclk, .aresetn,
        .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
        .rd_valid(bv), .rd_ready(br), .rd_job(bj)
    );

    lrm_back u_back (
        .aclk, .aresetn,
        .job_valid(bv), .job_ready(br), .job(bj),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .result(m_axis_tdata)
    );

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking testbench for linear_range_map_rounded_u16
// drives samples and register writes, predicts each mapped value and compares in order
// depends on lrm_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
    import lrm_pkg::*;

    typedef struct {
        logic [DataW-1:0] sample;
        bit               known;
        logic [DataW-1:0] result;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [DataW-1:0]   s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DataW-1:0]   m_axis_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DataW-1:0]   cfg_data = '0;

    logic [DataW-1:0] src_lo, src_hi, tgt_lo, tgt_hi;
    logic [DataW-1:0] mapped_q[$];
    int               errors = 0;
    int               send_idle = 0;
    int               recv_idle = 0;
    bit               hold_recv = 1'b0;

    linear_range_map_rounded_u16 i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [DataW-1:0] map_sample(logic [DataW-1:0] x);
        logic [NumW-1:0] offset, span, delta, step;
        if (x < src_lo) return tgt_lo;
        if (x >= src_hi) return tgt_hi;
        offset = NumW'(x) - NumW'(src_lo);
        span = NumW'(src_hi) - NumW'(src_lo);
        delta = (tgt_hi < tgt_lo) ? NumW'(tgt_lo) - NumW'(tgt_hi)
                                  : NumW'(tgt_hi) - NumW'(tgt_lo);
        step = (offset * delta + span / 2) / span;
        if (tgt_hi < tgt_lo) return DataW'(NumW'(tgt_lo) - step);
        return DataW'(NumW'(tgt_lo) + step);
    endfunction

    task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [DataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SOURCE_LOW:  src_lo = value;
            REG_SOURCE_HIGH: src_hi = value;
            REG_TARGET_LOW:  tgt_lo = value;
            default:         tgt_hi = value;
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_ranges(logic [DataW-1:0] sl, sh, tl, th);
        wait_drained();
        write_reg(REG_SOURCE_LOW, sl);
        write_reg(REG_SOURCE_HIGH, sh);
        write_reg(REG_TARGET_LOW, tl);
        write_reg(REG_TARGET_HIGH, th);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [DataW-1:0] x, bit known, logic [DataW-1:0] want);
        logic [DataW-1:0] predicted;
        predicted = map_sample(x);
        if (known && predicted != want) report_mismatch("table", predicted, want);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        do @(posedge aclk); while (!s_axis_tready);
        mapped_q.push_back(known ? want : predicted);
    endtask

    function automatic logic [DataW-1:0] rand_sample();
        case ($urandom_range(9))
            0: return src_lo;
            1: return src_hi;
            2: return src_hi - 1'b1;
            3: return src_lo - 1'b1;
            4: return 16'hffff;
            5: return 16'h0000;
            default: return DataW'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (mapped_q.size() == 0) begin
                report_mismatch("unexpected", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata !== mapped_q[0])
                    report_mismatch("mapped_value", m_axis_tdata, mapped_q[0]);
                void'(mapped_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= aresetn && !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        stim_row_t rows[$];
        int n;
        src_lo = 0;
        src_hi = 16'hffff;
        tgt_lo = 0;
        tgt_hi = 16'hffff;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset
        rows.push_back('{16'h0000, 1, 16'h0000});
        rows.push_back('{16'hffff, 1, 16'hffff});
        rows.push_back('{16'hfffe, 1, 16'hfffe});
        rows.push_back('{16'h8000, 0, 0});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);

        // descending output, clamps at both ends
        rows.delete();
        set_ranges(16'd100, 16'd200, 16'd1000, 16'd0);
        rows.push_back('{16'd99, 1, 16'd1000});
        rows.push_back('{16'd100, 1, 16'd1000});
        rows.push_back('{16'd200, 1, 16'd0});
        rows.push_back('{16'd150, 1, 16'd500});
        rows.push_back('{16'd199, 0, 0});
        rows.push_back('{16'hffff, 1, 16'd0});
        rows.push_back('{16'h0000, 1, 16'd1000});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);

        // inverted and empty input range
        rows.delete();
        set_ranges(16'd500, 16'd400, 16'd7, 16'd9);
        rows.push_back('{16'd499, 1, 16'd7});
        rows.push_back('{16'd450, 1, 16'd7});
        rows.push_back('{16'd500, 1, 16'd9});
        rows.push_back('{16'hffff, 1, 16'd9});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);
        rows.delete();
        set_ranges(16'd300, 16'd300, 16'hffff, 16'h0000);
        rows.push_back('{16'd299, 1, 16'hffff});
        rows.push_back('{16'd300, 1, 16'h0000});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);

        // widest product and rounding on a unit span
        rows.delete();
        set_ranges(16'h0000, 16'hffff, 16'hffff, 16'h0000);
        rows.push_back('{16'h0000, 1, 16'hffff});
        rows.push_back('{16'hfffe, 0, 0});
        rows.push_back('{16'h5555, 0, 0});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);
        rows.delete();
        set_ranges(16'hfffe, 16'hffff, 16'd0, 16'hffff);
        rows.push_back('{16'hfffe, 1, 16'd0});
        rows.push_back('{16'hffff, 1, 16'hffff});
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].result);

        // random phases: settings change between phases
        for (int phase = 0; phase < 24; phase++) begin
            send_idle = (phase < 8) ? 20 : (phase < 16) ? 51 : 0;
            recv_idle = (phase < 8) ? 51 : (phase < 16) ? 20 : 0;
            case (phase % 4)
                0: set_ranges(DataW'($urandom), DataW'($urandom), DataW'($urandom),
                              DataW'($urandom));
                1: begin
                    n = $urandom_range(1000);
                    set_ranges(16'(n), 16'(n + $urandom_range(1, 3000)),
                               DataW'($urandom), DataW'($urandom));
                end
                2: set_ranges($urandom_range(1) ? 16'h0000 : 16'hffff,
                              $urandom_range(1) ? 16'h0000 : 16'hffff,
                              $urandom_range(1) ? 16'h0000 : 16'hffff,
                              $urandom_range(1) ? 16'h0000 : 16'hffff);
                default: begin
                    n = $urandom_range(16'hff00);
                    set_ranges(16'(n), 16'(n + $urandom_range(1, 255)),
                               DataW'($urandom), DataW'($urandom));
                end
            endcase
            if (phase == 5) begin
                hold_recv = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge aclk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 70; k++) send_sample(rand_sample(), 0, '0);
            if (phase == 10) wait_drained();
        end

        wait_drained();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lrm_pkg.sv
rtl/core/lrm_front.sv
rtl/core/lrm_queue.sv
rtl/core/lrm_back.sv
rtl/core/linear_range_map_rounded_u16.sv
verif/tb_top.sv
